// ===== rtl/ntpb_pkg.sv =====
// Types and constants shared by the nearest-timestamp pose buffer.
package ntpb_pkg;

   localparam logic [29:0] NS_PER_SEC     = 30'd1000000000;
   localparam logic [35:0] MAX_AGE_RESET  = 36'd100000000;

   localparam logic ACTION_ADD   = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   typedef struct packed {
      logic               action;
      logic        [30:0] stamp_sec;
      logic        [29:0] stamp_nanosec;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] heading;
   } ntpb_req_type;

   typedef struct packed {
      logic               found;
      logic signed [31:0] match_x;
      logic signed [31:0] match_y;
      logic signed [31:0] match_heading;
   } ntpb_rsp_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] heading;
   } ntpb_pose_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_WRITE,
      ST_SCAN,
      ST_POSE_READ,
      ST_DELIVER
   } ntpb_state_type;

endpackage

// ===== rtl/nearest_timestamp_pose_buffer.sv =====
// Nearest-timestamp pose history: ring store, sequential scan and result register.
//
// Keeps up to HISTORY_DEPTH timestamped poses in a ring held in two single-port
// synchronous memories (stamps, poses). One transaction is worked at a time. An add
// forms the stamp (ST_MUL, ST_SUM), writes it (ST_WRITE) and returns to idle before
// the next transaction can be taken. A query forms the stamp the same way, reads one
// stamp per stored entry through the single read port of the stamp memory (none with
// an empty history), drains the compare pipeline, reads the pose, loads the result
// when the result register is free and returns to idle. Its result is held in an
// output register, so further transactions are accepted while it waits on rsp_stall;
// a second query result waits until the first has left. Ties on the time gap go to
// the older entry. When the gap exceeds max_age_ns or the history is empty, found is
// 0 and the pose fields are zero.
module nearest_timestamp_pose_buffer
   import ntpb_pkg::*;
#(
   parameter int HISTORY_DEPTH = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  ntpb_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output ntpb_rsp_type rsp_payload,
   input  logic         csr_write_enable,
   input  logic [35:0]  csr_write_data
);

   localparam int IDX_W = $clog2(HISTORY_DEPTH);
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(HISTORY_DEPTH);
   localparam logic [IDX_W:0]   DEPTH_WIDE = (IDX_W + 1)'(HISTORY_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(HISTORY_DEPTH - 1);

   logic [62:0]   stamp_mem [HISTORY_DEPTH];
   ntpb_pose_type pose_mem  [HISTORY_DEPTH];

   ntpb_state_type   state_ff, state_in;
   ntpb_req_type     req_ff;
   logic [60:0]      product_ff;
   logic [62:0]      stamp_ff;
   logic [35:0]      max_age_ff;
   logic [IDX_W-1:0] oldest_ff, oldest_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] scan_addr_ff;
   logic [CNT_W-1:0] scan_left_ff;
   logic             rd_valid_ff;
   logic [IDX_W-1:0] rd_slot_ff;
   logic [62:0]      stamp_rd_ff;
   logic             diff_valid_ff;
   logic [62:0]      diff_ff;
   logic [IDX_W-1:0] diff_slot_ff;
   logic             have_ff;
   logic [62:0]      best_diff_ff;
   logic [IDX_W-1:0] best_slot_ff;
   ntpb_pose_type    pose_rd_ff;
   ntpb_rsp_type     rsp_ff, rsp_in;
   logic             rsp_valid_ff;

   logic             stamp_wr_en;
   logic             scan_rd_en;
   logic             pose_rd_en;
   logic             rsp_load;
   logic [IDX_W:0]   append_sum;
   logic [IDX_W-1:0] wr_slot;
   logic [IDX_W-1:0] oldest_next;
   logic [IDX_W-1:0] scan_addr_next;
   logic [62:0]      abs_diff;
   logic             found;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MUL;
         end
         ST_MUL:  state_in = ST_SUM;
         ST_SUM: begin
            if (req_ff.action == ACTION_ADD) state_in = ST_WRITE;
            else if (count_ff == '0) state_in = ST_POSE_READ;
            else state_in = ST_SCAN;
         end
         ST_WRITE: state_in = ST_IDLE;
         ST_SCAN: begin
            if (scan_left_ff == '0 && !rd_valid_ff && !diff_valid_ff) begin
               state_in = ST_POSE_READ;
            end
         end
         ST_POSE_READ: state_in = ST_DELIVER;
         ST_DELIVER: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall   = 1'b1;
      stamp_wr_en = 1'b0;
      scan_rd_en  = 1'b0;
      pose_rd_en  = 1'b0;
      rsp_load    = 1'b0;
      case (state_ff)
         ST_IDLE:      req_stall   = reset;
         ST_WRITE:     stamp_wr_en = 1'b1;
         ST_SCAN:      scan_rd_en  = (scan_left_ff != '0);
         ST_POSE_READ: pose_rd_en  = 1'b1;
         ST_DELIVER:   rsp_load    = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   // ring bookkeeping
   always_comb begin
      append_sum  = {1'b0, oldest_ff} + (IDX_W + 1)'(count_ff);
      oldest_next = (oldest_ff == LAST_IDX) ? '0 : oldest_ff + 1'b1;
      oldest_in   = oldest_ff;
      count_in    = count_ff;
      if (count_ff < DEPTH_CNT) begin
         wr_slot = (append_sum >= DEPTH_WIDE) ? IDX_W'(append_sum - DEPTH_WIDE)
                                              : IDX_W'(append_sum);
         if (stamp_wr_en) count_in = count_ff + 1'b1;
      end else begin
         wr_slot = oldest_ff;
         if (stamp_wr_en) oldest_in = oldest_next;
      end
   end

   assign scan_addr_next = (scan_addr_ff == LAST_IDX) ? '0 : scan_addr_ff + 1'b1;
   assign abs_diff = (stamp_rd_ff >= stamp_ff) ? stamp_rd_ff - stamp_ff
                                               : stamp_ff - stamp_rd_ff;

   // result
   always_comb begin
      found  = have_ff && (best_diff_ff <= 63'(max_age_ff));
      rsp_in = '0;
      if (found) begin
         rsp_in.found         = 1'b1;
         rsp_in.match_x       = pose_rd_ff.x;
         rsp_in.match_y       = pose_rd_ff.y;
         rsp_in.match_heading = pose_rd_ff.heading;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         max_age_ff    <= MAX_AGE_RESET;
         oldest_ff     <= '0;
         count_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         diff_valid_ff <= 1'b0;
         have_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         oldest_ff     <= oldest_in;
         count_ff      <= count_in;
         rd_valid_ff   <= scan_rd_en;
         diff_valid_ff <= rd_valid_ff;
         if (csr_write_enable) max_age_ff <= csr_write_data;
         if (state_ff == ST_SUM) begin
            have_ff <= 1'b0;
         end else if (diff_valid_ff) begin
            have_ff <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) req_ff <= req_payload;
      product_ff <= 61'(req_ff.stamp_sec) * 61'(NS_PER_SEC);
      if (state_ff == ST_SUM) begin
         stamp_ff     <= 63'(product_ff) + 63'(req_ff.stamp_nanosec);
         scan_addr_ff <= oldest_ff;
         scan_left_ff <= count_ff;
      end else if (scan_rd_en) begin
         scan_addr_ff <= scan_addr_next;
         scan_left_ff <= scan_left_ff - 1'b1;
      end
      rd_slot_ff   <= scan_addr_ff;
      diff_ff      <= abs_diff;
      diff_slot_ff <= rd_slot_ff;
      if (diff_valid_ff && (!have_ff || diff_ff < best_diff_ff)) begin
         best_diff_ff <= diff_ff;
         best_slot_ff <= diff_slot_ff;
      end
      if (rsp_load) rsp_ff <= rsp_in;
   end

   // stamp and pose memories
   always_ff @(posedge clock) begin
      if (stamp_wr_en) stamp_mem[wr_slot] <= stamp_ff;
      if (scan_rd_en) stamp_rd_ff <= stamp_mem[scan_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (stamp_wr_en) begin
         pose_mem[wr_slot] <= '{x: req_ff.pos_x, y: req_ff.pos_y, heading: req_ff.heading};
      end
      if (pose_rd_en) pose_rd_ff <= pose_mem[best_slot_ff];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assert property (@(posedge clock) disable iff (reset) count_ff <= DEPTH_CNT)
      else $error("history count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      count_ff < DEPTH_CNT |-> oldest_ff == '0)
      else $error("ring start moved before history filled");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POSE_READ |-> !rd_valid_ff && !diff_valid_ff)
      else $error("pose read issued with scan still in flight");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DELIVER))
      else $error("result raised outside delivery");

endmodule

// ===== test/nearest_timestamp_pose_buffer_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the nearest-timestamp pose buffer.
module nearest_timestamp_pose_buffer_tb;
   import ntpb_pkg::*;

   localparam int          HISTORY_DEPTH = 256;
   localparam int          IDX_W         = $clog2(HISTORY_DEPTH);
   localparam int          DRAIN_CYCLES  = 2 * HISTORY_DEPTH + 40;
   localparam int          LIMIT_CYCLES  = 2000000;
   localparam logic [35:0] AGE_HIGH      = 36'd60000000000;
   localparam logic [35:0] AGE_ALL_ONES  = 36'hFFFFFFFFF;
   localparam logic [30:0] SEC_TOP       = 31'h7FFFFFFF;
   localparam logic [29:0] NSEC_TOP      = 30'h3FFFFFFF;

   logic         clock            = 1'b0;
   logic         reset            = 1'b1;
   logic         req_valid        = 1'b0;
   logic         req_stall;
   ntpb_req_type req_payload      = '0;
   logic         rsp_valid;
   logic         rsp_stall        = 1'b0;
   ntpb_rsp_type rsp_payload;
   logic         csr_write_enable = 1'b0;
   logic [35:0]  csr_write_data   = '0;

   logic [62:0]      stamp_hist [HISTORY_DEPTH];
   ntpb_pose_type    pose_hist  [HISTORY_DEPTH];
   logic [IDX_W-1:0] oldest_slot  = '0;
   int               stored_total = 0;
   logic [35:0]      age_limit    = MAX_AGE_RESET;

   ntpb_rsp_type pose_answers[$];
   int           fail_count  = 0;
   int           cycle_count = 0;
   bit           quiet       = 1'b0;

   nearest_timestamp_pose_buffer #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [62:0] nanosec_stamp(input ntpb_req_type item);
      return {32'd0, item.stamp_sec} * 63'd1000000000 + {33'd0, item.stamp_nanosec};
   endfunction

   function automatic void track_pose_history(input ntpb_req_type item);
      logic [62:0]      stamp;
      logic [62:0]      gap;
      logic [62:0]      best_gap;
      logic [IDX_W-1:0] best_slot;
      logic [IDX_W-1:0] slot;
      bit               have;
      ntpb_rsp_type     answer;
      stamp = nanosec_stamp(item);
      if (item.action == ACTION_ADD) begin
         if (stored_total < HISTORY_DEPTH) begin
            slot = IDX_W'((int'(oldest_slot) + stored_total) % HISTORY_DEPTH);
            stored_total++;
         end else begin
            slot = oldest_slot;
            oldest_slot = IDX_W'((int'(oldest_slot) + 1) % HISTORY_DEPTH);
         end
         stamp_hist[slot] = stamp;
         pose_hist[slot]  = '{x: item.pos_x, y: item.pos_y, heading: item.heading};
         return;
      end
      best_gap  = '0;
      best_slot = '0;
      have      = 1'b0;
      for (int k = 0; k < stored_total; k++) begin
         slot = IDX_W'((int'(oldest_slot) + k) % HISTORY_DEPTH);
         gap  = (stamp_hist[slot] >= stamp) ? stamp_hist[slot] - stamp
                                            : stamp - stamp_hist[slot];
         if (!have || gap < best_gap) begin
            best_gap  = gap;
            best_slot = slot;
            have      = 1'b1;
         end
      end
      answer = '0;
      if (have && best_gap <= {27'd0, age_limit}) begin
         answer.found         = 1'b1;
         answer.match_x       = pose_hist[best_slot].x;
         answer.match_y       = pose_hist[best_slot].y;
         answer.match_heading = pose_hist[best_slot].heading;
      end
      pose_answers = {pose_answers, answer};
   endfunction

   function automatic ntpb_req_type make_req(input logic action, input logic [30:0] sec,
                                             input logic [29:0] nsec,
                                             input logic [31:0] x, input logic [31:0] y,
                                             input logic [31:0] h);
      ntpb_req_type item;
      item.action        = action;
      item.stamp_sec     = sec;
      item.stamp_nanosec = nsec;
      item.pos_x         = x;
      item.pos_y         = y;
      item.heading       = h;
      return item;
   endfunction

   function automatic ntpb_req_type random_req(input logic action, input logic [30:0] sec,
                                               input logic [29:0] nsec);
      return make_req(action, sec, nsec, $urandom, $urandom, $urandom);
   endfunction

   task automatic send_req(input ntpb_req_type item);
      int idle;
      idle = pick_gap();
      repeat (idle) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_pose_history(item);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pose_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_max_age(input logic [35:0] value);
      wait_idle();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      age_limit = value;
   endtask

   initial begin : rsp_stall_gen
      int n;
      forever begin
         n = pick_gap();
         repeat (n) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         n = $urandom_range(1, 8);
         repeat (n) begin
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : rsp_checker
      ntpb_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pose_answers.size() == 0) begin
            $error("rsp transaction with no pending query");
            fail_count++;
         end else begin
            want = pose_answers[0];
            pose_answers.delete(0);
            if (rsp_payload.found !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_payload.found);
               fail_count++;
            end
            if (rsp_payload.match_x !== want.match_x) begin
               $error("match_x: expected %0d, actual %0d", want.match_x,
                      rsp_payload.match_x);
               fail_count++;
            end
            if (rsp_payload.match_y !== want.match_y) begin
               $error("match_y: expected %0d, actual %0d", want.match_y,
                      rsp_payload.match_y);
               fail_count++;
            end
            if (rsp_payload.match_heading !== want.match_heading) begin
               $error("match_heading: expected %0d, actual %0d", want.match_heading,
                      rsp_payload.match_heading);
               fail_count++;
            end
         end
      end
   end

   task automatic test_empty_history();
      send_req(random_req(ACTION_QUERY, 31'($urandom), 30'($urandom)));
   endtask

   task automatic test_field_extremes();
      send_req(make_req(ACTION_ADD, '0, '0, 32'h80000000, 32'h80000000, 32'h80000000));
      send_req(make_req(ACTION_ADD, SEC_TOP, NSEC_TOP,
                        32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
      send_req(make_req(ACTION_QUERY, '0, '0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
      send_req(make_req(ACTION_QUERY, SEC_TOP, NSEC_TOP, '0, '0, '0));
      send_req(random_req(ACTION_QUERY, 31'h40000000, 30'd0));
   endtask

   task automatic test_unnormalized_nanosec();
      send_req(random_req(ACTION_ADD, 31'd5, 30'd1000000500));
      send_req(random_req(ACTION_QUERY, 31'd6, 30'd500));
   endtask

   task automatic test_tie_older_wins();
      send_req(random_req(ACTION_ADD, 31'd99, 30'd999999950));
      send_req(random_req(ACTION_ADD, 31'd100, 30'd50));
      send_req(random_req(ACTION_QUERY, 31'd100, 30'd0));
      send_req(random_req(ACTION_ADD, 31'd100, 30'd50));
      send_req(random_req(ACTION_QUERY, 31'd100, 30'd50));
   endtask

   task automatic test_age_limit_edges();
      set_max_age(36'd0);
      send_req(random_req(ACTION_ADD, 31'd1000, 30'd500));
      send_req(random_req(ACTION_QUERY, 31'd1000, 30'd500));
      send_req(random_req(ACTION_QUERY, 31'd1000, 30'd501));
      set_max_age(36'd1);
      send_req(random_req(ACTION_QUERY, 31'd1000, 30'd501));
      send_req(random_req(ACTION_QUERY, 31'd1000, 30'd502));
   endtask

   task automatic run_cluster(input int count, input int add_pct, input int span);
      logic [30:0]  base;
      logic [30:0]  sec;
      logic [29:0]  nsec;
      logic [30:0]  last_sec;
      logic [29:0]  last_nsec;
      logic         action;
      int           roll;
      base      = 31'($urandom_range(0, 32'h7FFFFFFF - span));
      last_sec  = base;
      last_nsec = '0;
      repeat (count) begin
         action = ($urandom_range(0, 99) < add_pct) ? ACTION_ADD : ACTION_QUERY;
         roll   = $urandom_range(0, 99);
         sec    = 31'(base + $urandom_range(0, span));
         nsec   = ($urandom_range(0, 15) == 0) ? 30'($urandom_range(0, NSEC_TOP))
                                               : 30'($urandom_range(0, 999999999));
         if (roll < 15) begin
            sec  = last_sec;
            nsec = last_nsec;
         end
         send_req(random_req(action, sec, nsec));
         if (action == ACTION_ADD) begin
            last_sec  = sec;
            last_nsec = nsec;
         end
      end
   endtask

   task automatic test_clustered_traffic();
      set_max_age(MAX_AGE_RESET);
      run_cluster(150, 60, 20);
   endtask

   task automatic test_ring_overflow();
      set_max_age(36'($urandom_range(1, 32'hFFFFFFFF)) * 36'd14);
      run_cluster(250, 85, 4);
   endtask

   task automatic test_random_noise();
      set_max_age(AGE_HIGH);
      repeat (75) begin
         send_req(random_req(1'($urandom_range(0, 1)), 31'($urandom), 30'($urandom)));
      end
   endtask

   task automatic test_back_to_back();
      set_max_age(AGE_ALL_ONES);
      quiet = 1'b1;
      run_cluster(75, 50, 200);
      quiet = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_history();
      test_field_extremes();
      test_unnormalized_nanosec();
      test_tie_older_wins();
      test_age_limit_edges();
      test_clustered_traffic();
      test_ring_overflow();
      test_random_noise();
      test_back_to_back();
      wait_idle();
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== nearest_timestamp_pose_buffer.f =====
rtl/ntpb_pkg.sv
rtl/nearest_timestamp_pose_buffer.sv
test/nearest_timestamp_pose_buffer_tb.sv
